### sv/tkz_pkg.sv
`timescale 1ns / 1ps

package tkz_pkg;

    localparam int MAX_TOKENS_DEFAULT    = 64;
    localparam int POSITION_BITS_DEFAULT = 16;

    // Field widths of the channels.
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 16;
    localparam int CHILD_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [CHILD_W-1:0] CHILD_MAX   = 6'd63;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_OBJECT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRAY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRING    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PRIMITIVE = 2'd3;

    // Parse status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OPEN_STR   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd5;

    // Scanner modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_ESCAPE = 2'd2;
    localparam logic [1:0] MODE_PRIM   = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic is_open;
        logic is_close;
        logic is_array;
        logic is_quote;
        logic is_bslash;
        logic is_skip;
        logic is_prim_end;
    } byte_class_t;

endpackage

### sv/tkz_ifs.sv
`timescale 1ns / 1ps

interface tkz_text_if;
    logic                        valid;
    logic                        ready;
    logic [tkz_pkg::BYTE_W-1:0]  text_byte;
    logic                        end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tkz_token_if;
    logic                          valid;
    logic                          ready;
    logic                          token_valid;
    logic [tkz_pkg::INDEX_W-1:0]   token_index;
    logic [tkz_pkg::KIND_W-1:0]    token_kind;
    logic [tkz_pkg::POS_W-1:0]     token_start;
    logic [tkz_pkg::POS_W-1:0]     token_end;
    logic                          token_closed;
    logic [tkz_pkg::CHILD_W-1:0]   child_count;
    logic [tkz_pkg::COUNT_W-1:0]   token_count;
    logic [tkz_pkg::STATUS_W-1:0]  parse_status;
    logic                          last_result;

    modport source (output valid, output token_valid, output token_index, output token_kind,
                    output token_start, output token_end, output token_closed,
                    output child_count, output token_count, output parse_status,
                    output last_result, input ready);
    modport sink   (input valid, input token_valid, input token_index, input token_kind,
                    input token_start, input token_end, input token_closed,
                    input child_count, input token_count, input parse_status,
                    input last_result, output ready);
endinterface

interface tkz_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tkz_pkg::LIMIT_W-1:0]  token_limit;

    modport source (output valid, output token_limit, input ready);
    modport sink   (input valid, input token_limit, output ready);
endinterface

### sv/tkz_ram.sv
`timescale 1ns / 1ps

module tkz_ram #(
    parameter int DEPTH = tkz_pkg::MAX_TOKENS_DEFAULT,
    parameter int AW    = 6,
    parameter int W     = 41
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### sv/tkz_class.sv
`timescale 1ns / 1ps

module tkz_class (
    input  logic [tkz_pkg::BYTE_W-1:0] byte_value,
    output tkz_pkg::byte_class_t       cls
);

    logic ws;

    always_comb
    begin
        ws = (byte_value == tkz_pkg::CH_TAB) || (byte_value == tkz_pkg::CH_CR) ||
             (byte_value == tkz_pkg::CH_LF) || (byte_value == tkz_pkg::CH_SPACE);
        cls.is_open     = (byte_value == tkz_pkg::CH_LBRACE) ||
                          (byte_value == tkz_pkg::CH_LBRACK);
        cls.is_close    = (byte_value == tkz_pkg::CH_RBRACE) ||
                          (byte_value == tkz_pkg::CH_RBRACK);
        cls.is_array    = (byte_value == tkz_pkg::CH_LBRACK) ||
                          (byte_value == tkz_pkg::CH_RBRACK);
        cls.is_quote    = (byte_value == tkz_pkg::CH_QUOTE);
        cls.is_bslash   = (byte_value == tkz_pkg::CH_BSLASH);
        cls.is_skip     = ws || (byte_value == tkz_pkg::CH_COLON) ||
                          (byte_value == tkz_pkg::CH_COMMA);
        cls.is_prim_end = ws || (byte_value == tkz_pkg::CH_COMMA) ||
                          (byte_value == tkz_pkg::CH_RBRACE) ||
                          (byte_value == tkz_pkg::CH_RBRACK);
    end

endmodule

### sv/json_tokenizer_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload                                      Request moves
// text     in         text_byte, end_of_text                       one byte of text
// tokens   out        token fields, token_count, parse_status...   one table entry
// cfg      in         token_limit                                  one limit write
//
// Steps: a byte in open text passes S_BYTE, S_HANDLE, S_POSINC and S_EOT; a byte inside
// a string or primitive skips S_HANDLE. Creating a token adds the table write and, if
// there is a parent, a read and write of its child count; the byte that ends a
// primitive is then handled in open text as well. A closer walks the token table
// downwards through the single memory port, reading each entry visited. An emitted
// entry is read and then given out. Reset clears the control state; the token table needs
// no clearing, as only entries below the fill count are ever used. A waiting result
// stalls the sequencer only at the point where the next result would be loaded.
module json_tokenizer_core #(
    parameter int MAX_TOKENS    = tkz_pkg::MAX_TOKENS_DEFAULT,
    parameter int POSITION_BITS = tkz_pkg::POSITION_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    tkz_text_if.sink          text,
    tkz_token_if.source       tokens,
    tkz_cfg_if.sink           cfg
);

    localparam int P  = POSITION_BITS;
    localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int LW = CW + tkz_pkg::LIMIT_W;
    // Table word: kind, start, end, closed flag, child count.
    localparam int WW = tkz_pkg::KIND_W + 2 * P + 1 + tkz_pkg::CHILD_W;
    localparam int CH_LO = 0;
    localparam int CL_B  = tkz_pkg::CHILD_W;
    localparam int EN_LO = CL_B + 1;
    localparam int ST_LO = EN_LO + P;
    localparam int KD_LO = ST_LO + P;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_BYTE     = 4'd1;
    localparam logic [3:0] S_HANDLE   = 4'd2;
    localparam logic [3:0] S_ALLOC    = 4'd3;
    localparam logic [3:0] S_PAR_RD   = 4'd4;
    localparam logic [3:0] S_PAR_WR   = 4'd5;
    localparam logic [3:0] S_AFTER    = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_SCAN_CHK = 4'd8;
    localparam logic [3:0] S_POSINC   = 4'd9;
    localparam logic [3:0] S_EOT      = 4'd10;
    localparam logic [3:0] S_EMIT_RD  = 4'd11;
    localparam logic [3:0] S_EMIT_OUT = 4'd12;

    // Where the sequencer goes once a token has been allocated.
    localparam logic [1:0] RET_STR  = 2'd0;
    localparam logic [1:0] RET_PRIM = 2'd1;
    localparam logic [1:0] RET_OPEN = 2'd2;
    localparam logic [1:0] RET_EOT  = 2'd3;

    logic [3:0]                    state_reg, state_next;
    logic [tkz_pkg::BYTE_W-1:0]    byte_reg, byte_next;
    logic                          eot_reg, eot_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [P-1:0]                  pos_reg, pos_next;
    logic [P-1:0]                  scan_start_reg, scan_start_next;
    logic [tkz_pkg::STATUS_W-1:0]  err_reg, err_next;
    logic [CW-1:0]                 next_free_reg, next_free_next;
    logic                          parent_valid_reg, parent_valid_next;
    logic [IW-1:0]                 parent_reg, parent_next;
    logic [CW-1:0]                 cursor_reg, cursor_next;
    logic [tkz_pkg::LIMIT_W-1:0]   limit_reg;
    logic [tkz_pkg::KIND_W-1:0]    akind_reg, akind_next;
    logic [P-1:0]                  astart_reg, astart_next;
    logic [P-1:0]                  aend_reg, aend_next;
    logic                          aclosed_reg, aclosed_next;
    logic [1:0]                    ret_reg, ret_next;
    logic [IW-1:0]                 new_idx_reg, new_idx_next;
    logic [CW-1:0]                 scan_i_reg, scan_i_next;
    logic                          phase_reg, phase_next;
    logic [CW-1:0]                 emit_idx_reg, emit_idx_next;

    logic                          ov_reg, ov_next;
    logic                          o_tvalid_reg, o_tvalid_next;
    logic [tkz_pkg::INDEX_W-1:0]   o_index_reg, o_index_next;
    logic [tkz_pkg::KIND_W-1:0]    o_kind_reg, o_kind_next;
    logic [tkz_pkg::POS_W-1:0]     o_start_reg, o_start_next;
    logic [tkz_pkg::POS_W-1:0]     o_end_reg, o_end_next;
    logic                          o_closed_reg, o_closed_next;
    logic [tkz_pkg::CHILD_W-1:0]   o_child_reg, o_child_next;
    logic [tkz_pkg::COUNT_W-1:0]   o_count_reg, o_count_next;
    logic [tkz_pkg::STATUS_W-1:0]  o_status_reg, o_status_next;
    logic                          o_last_reg, o_last_next;

    logic                          mem_we, mem_re;
    logic [IW-1:0]                 mem_addr;
    logic [WW-1:0]                 mem_wdata, mem_rdata;
    tkz_pkg::byte_class_t          cls;

    logic                          table_full;
    logic [CW-1:0]                 scan_m1;
    logic [tkz_pkg::CHILD_W-1:0]   rd_child;
    logic [CW:0]                   emit_inc;
    logic                          emit_valid;
    logic [P+tkz_pkg::POS_W-1:0]   start_wide, end_wide;
    logic [CW+tkz_pkg::INDEX_W-1:0] index_wide;
    logic [CW+tkz_pkg::COUNT_W-1:0] count_wide;

    tkz_class u_class (
        .byte_value (byte_reg),
        .cls        (cls)
    );

    tkz_ram #(
        .DEPTH (MAX_TOKENS),
        .AW    (IW),
        .W     (WW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign text.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign tokens.valid        = ov_reg;
    assign tokens.token_valid  = o_tvalid_reg;
    assign tokens.token_index  = o_index_reg;
    assign tokens.token_kind   = o_kind_reg;
    assign tokens.token_start  = o_start_reg;
    assign tokens.token_end    = o_end_reg;
    assign tokens.token_closed = o_closed_reg;
    assign tokens.child_count  = o_child_reg;
    assign tokens.token_count  = o_count_reg;
    assign tokens.parse_status = o_status_reg;
    assign tokens.last_result  = o_last_reg;

    // The usable limit is the smaller of the register and the table depth.
    assign table_full = (LW'(next_free_reg) >= LW'(limit_reg)) ||
                        (next_free_reg >= CW'(MAX_TOKENS));
    assign scan_m1    = scan_i_reg - 1'b1;
    assign rd_child   = mem_rdata[CL_B-1:CH_LO];
    assign emit_inc   = {1'b0, emit_idx_reg} + 1'b1;
    assign emit_valid = (emit_idx_reg < next_free_reg);
    assign start_wide = {{tkz_pkg::POS_W{1'b0}}, mem_rdata[KD_LO-1:ST_LO]};
    assign end_wide   = {{tkz_pkg::POS_W{1'b0}}, mem_rdata[ST_LO-1:EN_LO]};
    assign index_wide = {{tkz_pkg::INDEX_W{1'b0}}, emit_idx_reg};
    assign count_wide = {{tkz_pkg::COUNT_W{1'b0}}, next_free_reg};

    always_comb
    begin
        state_next        = state_reg;
        byte_next         = byte_reg;
        eot_next          = eot_reg;
        mode_next         = mode_reg;
        pos_next          = pos_reg;
        scan_start_next   = scan_start_reg;
        err_next          = err_reg;
        next_free_next    = next_free_reg;
        parent_valid_next = parent_valid_reg;
        parent_next       = parent_reg;
        cursor_next       = cursor_reg;
        akind_next        = akind_reg;
        astart_next       = astart_reg;
        aend_next         = aend_reg;
        aclosed_next      = aclosed_reg;
        ret_next          = ret_reg;
        new_idx_next      = new_idx_reg;
        scan_i_next       = scan_i_reg;
        phase_next        = phase_reg;
        emit_idx_next     = emit_idx_reg;
        ov_next           = ov_reg;
        o_tvalid_next     = o_tvalid_reg;
        o_index_next      = o_index_reg;
        o_kind_next       = o_kind_reg;
        o_start_next      = o_start_reg;
        o_end_next        = o_end_reg;
        o_closed_next     = o_closed_reg;
        o_child_next      = o_child_reg;
        o_count_next      = o_count_reg;
        o_status_next     = o_status_reg;
        o_last_next       = o_last_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_addr          = next_free_reg[IW-1:0];
        mem_wdata         = mem_rdata;

        if (ov_reg && tokens.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (text.valid)
                begin
                    byte_next = text.text_byte;
                    eot_next  = text.end_of_text;
                    if (cursor_reg != '0)
                    begin
                        // Emission in progress: the byte itself is ignored.
                        emit_idx_next = cursor_reg;
                        state_next    = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
            end

            S_BYTE:
            begin
                if (err_reg != tkz_pkg::ST_OK)
                begin
                    state_next = S_EOT;
                end
                else if (pos_reg >= {P{1'b1}})
                begin
                    err_next   = tkz_pkg::ST_TOO_LONG;
                    state_next = S_EOT;
                end
                else
                begin
                    case (mode_reg)
                        tkz_pkg::MODE_STRING:
                        begin
                            if (cls.is_quote)
                            begin
                                mode_next    = tkz_pkg::MODE_IDLE;
                                akind_next   = tkz_pkg::KIND_STRING;
                                astart_next  = scan_start_reg;
                                aend_next    = pos_reg;
                                aclosed_next = 1'b1;
                                ret_next     = RET_STR;
                                state_next   = S_ALLOC;
                            end
                            else
                            begin
                                if (cls.is_bslash)
                                begin
                                    mode_next = tkz_pkg::MODE_ESCAPE;
                                end
                                state_next = S_POSINC;
                            end
                        end
                        tkz_pkg::MODE_ESCAPE:
                        begin
                            mode_next  = tkz_pkg::MODE_STRING;
                            state_next = S_POSINC;
                        end
                        tkz_pkg::MODE_PRIM:
                        begin
                            if (cls.is_prim_end)
                            begin
                                mode_next    = tkz_pkg::MODE_IDLE;
                                akind_next   = tkz_pkg::KIND_PRIMITIVE;
                                astart_next  = scan_start_reg;
                                aend_next    = pos_reg;
                                aclosed_next = 1'b1;
                                ret_next     = RET_PRIM;
                                state_next   = S_ALLOC;
                            end
                            else
                            begin
                                state_next = S_POSINC;
                            end
                        end
                        default:
                        begin
                            state_next = S_HANDLE;
                        end
                    endcase
                end
            end

            S_HANDLE:
            begin
                if (cls.is_open)
                begin
                    akind_next   = cls.is_array ? tkz_pkg::KIND_ARRAY : tkz_pkg::KIND_OBJECT;
                    astart_next  = pos_reg;
                    aend_next    = '0;
                    aclosed_next = 1'b0;
                    ret_next     = RET_OPEN;
                    state_next   = S_ALLOC;
                end
                else if (cls.is_close)
                begin
                    scan_i_next = next_free_reg;
                    phase_next  = 1'b0;
                    state_next  = S_SCAN;
                end
                else if (cls.is_quote)
                begin
                    mode_next       = tkz_pkg::MODE_STRING;
                    scan_start_next = pos_reg + 1'b1;
                    state_next      = S_POSINC;
                end
                else if (cls.is_skip)
                begin
                    state_next = S_POSINC;
                end
                else
                begin
                    mode_next       = tkz_pkg::MODE_PRIM;
                    scan_start_next = pos_reg;
                    state_next      = S_POSINC;
                end
            end

            S_ALLOC:
            begin
                if (table_full)
                begin
                    if (err_reg == tkz_pkg::ST_OK)
                    begin
                        err_next = tkz_pkg::ST_FULL;
                    end
                    if (ret_reg == RET_EOT)
                    begin
                        emit_idx_next = '0;
                        state_next    = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_POSINC;
                    end
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_addr       = next_free_reg[IW-1:0];
                    mem_wdata      = {akind_reg, astart_reg, aend_reg, aclosed_reg,
                                      {tkz_pkg::CHILD_W{1'b0}}};
                    new_idx_next   = next_free_reg[IW-1:0];
                    next_free_next = next_free_reg + 1'b1;
                    state_next     = parent_valid_reg ? S_PAR_RD : S_AFTER;
                end
            end

            S_PAR_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = parent_reg;
                state_next = S_PAR_WR;
            end

            S_PAR_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = parent_reg;
                mem_wdata = {mem_rdata[WW-1:CL_B],
                             (rd_child == tkz_pkg::CHILD_MAX) ? rd_child : rd_child + 1'b1};
                state_next = S_AFTER;
            end

            S_AFTER:
            begin
                case (ret_reg)
                    RET_OPEN:
                    begin
                        parent_valid_next = 1'b1;
                        parent_next       = new_idx_reg;
                        state_next        = S_POSINC;
                    end
                    RET_PRIM:
                    begin
                        // The byte that ended the primitive is handled in its own right.
                        state_next = S_HANDLE;
                    end
                    RET_EOT:
                    begin
                        emit_idx_next = '0;
                        state_next    = S_EMIT_RD;
                    end
                    default:
                    begin
                        state_next = S_POSINC;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_i_reg == '0)
                begin
                    if (!phase_reg)
                    begin
                        err_next = tkz_pkg::ST_UNMATCHED;
                    end
                    else
                    begin
                        parent_valid_next = 1'b0;
                    end
                    state_next = S_POSINC;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_addr    = scan_m1[IW-1:0];
                    scan_i_next = scan_m1;
                    state_next  = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (mem_rdata[CL_B])
                begin
                    state_next = S_SCAN;
                end
                else if (!phase_reg)
                begin
                    if (mem_rdata[WW-1:KD_LO] != {1'b0, cls.is_array})
                    begin
                        err_next   = tkz_pkg::ST_MISMATCH;
                        state_next = S_POSINC;
                    end
                    else
                    begin
                        // Close the container, then look further down for its parent.
                        mem_we     = 1'b1;
                        mem_addr   = scan_i_reg[IW-1:0];
                        mem_wdata  = {mem_rdata[WW-1:ST_LO], pos_reg + 1'b1, 1'b1, rd_child};
                        phase_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    parent_valid_next = 1'b1;
                    parent_next       = scan_i_reg[IW-1:0];
                    state_next        = S_POSINC;
                end
            end

            S_POSINC:
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = S_EOT;
            end

            S_EOT:
            begin
                if (!eot_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mode_next     = tkz_pkg::MODE_IDLE;
                    emit_idx_next = '0;
                    state_next    = S_EMIT_RD;
                    if (err_reg == tkz_pkg::ST_OK)
                    begin
                        if ((mode_reg == tkz_pkg::MODE_STRING) ||
                            (mode_reg == tkz_pkg::MODE_ESCAPE))
                        begin
                            err_next = tkz_pkg::ST_OPEN_STR;
                        end
                        else if (mode_reg == tkz_pkg::MODE_PRIM)
                        begin
                            akind_next   = tkz_pkg::KIND_PRIMITIVE;
                            astart_next  = scan_start_reg;
                            aend_next    = pos_reg;
                            aclosed_next = 1'b1;
                            ret_next     = RET_EOT;
                            state_next   = S_ALLOC;
                        end
                    end
                end
            end

            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = emit_idx_reg[IW-1:0];
                state_next = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (!ov_reg || tokens.ready)
                begin
                    ov_next       = 1'b1;
                    o_tvalid_next = emit_valid;
                    o_index_next  = emit_valid ? index_wide[tkz_pkg::INDEX_W-1:0] : '0;
                    o_kind_next   = emit_valid ? mem_rdata[WW-1:KD_LO] : '0;
                    o_start_next  = emit_valid ? start_wide[tkz_pkg::POS_W-1:0] : '0;
                    o_end_next    = (emit_valid && mem_rdata[CL_B]) ?
                                    end_wide[tkz_pkg::POS_W-1:0] : '0;
                    o_closed_next = emit_valid && mem_rdata[CL_B];
                    o_child_next  = emit_valid ? rd_child : '0;
                    o_count_next  = count_wide[tkz_pkg::COUNT_W-1:0];
                    o_status_next = err_reg;
                    o_last_next   = (emit_inc >= {1'b0, next_free_reg});
                    if (emit_inc >= {1'b0, next_free_reg})
                    begin
                        // Final entry: the document is done and the block starts afresh.
                        next_free_next    = '0;
                        parent_valid_next = 1'b0;
                        pos_next          = '0;
                        mode_next         = tkz_pkg::MODE_IDLE;
                        scan_start_next   = '0;
                        err_next          = tkz_pkg::ST_OK;
                        cursor_next       = '0;
                    end
                    else
                    begin
                        cursor_next = emit_inc[CW-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= tkz_pkg::MODE_IDLE;
            pos_reg          <= '0;
            scan_start_reg   <= '0;
            err_reg          <= tkz_pkg::ST_OK;
            next_free_reg    <= '0;
            parent_valid_reg <= 1'b0;
            cursor_reg       <= '0;
            limit_reg        <= tkz_pkg::LIMIT_RESET;
            ov_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            pos_reg          <= pos_next;
            scan_start_reg   <= scan_start_next;
            err_reg          <= err_next;
            next_free_reg    <= next_free_next;
            parent_valid_reg <= parent_valid_next;
            cursor_reg       <= cursor_next;
            ov_reg           <= ov_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.token_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        eot_reg       <= eot_next;
        parent_reg    <= parent_next;
        akind_reg     <= akind_next;
        astart_reg    <= astart_next;
        aend_reg      <= aend_next;
        aclosed_reg   <= aclosed_next;
        ret_reg       <= ret_next;
        new_idx_reg   <= new_idx_next;
        scan_i_reg    <= scan_i_next;
        phase_reg     <= phase_next;
        emit_idx_reg  <= emit_idx_next;
        o_tvalid_reg  <= o_tvalid_next;
        o_index_reg   <= o_index_next;
        o_kind_reg    <= o_kind_next;
        o_start_reg   <= o_start_next;
        o_end_reg     <= o_end_next;
        o_closed_reg  <= o_closed_next;
        o_child_reg   <= o_child_next;
        o_count_reg   <= o_count_next;
        o_status_reg  <= o_status_next;
        o_last_reg    <= o_last_next;
    end

`ifndef SYNTHESIS
    // The fill count never runs past the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= CW'(MAX_TOKENS))
        else $error("token fill count exceeds table depth");

    // A pending emission cursor always points at a stored entry.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg != '0) |-> (cursor_reg < next_free_reg))
        else $error("emission cursor beyond fill count");

    // An accepted byte always starts the sequencer.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer did not start after a request");

    // The first error stays until the document has been given out.
    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != tkz_pkg::ST_OK) && (state_reg != S_EMIT_OUT)) |=>
        (err_reg == $past(err_reg)))
        else $error("latched error changed");
`endif

endmodule
